### hw/rtl/gars_pkg.sv
// ----------------------------------------------------------------------------
// gars_pkg
// Shared types, command codes and the 5x7 font for the pixel streamer.
// ----------------------------------------------------------------------------
package gars_pkg;

  localparam int CoordW = 16;
  localparam int ColourW = 16;
  localparam int ScaleW = 4;
  localparam int GlyphW = 7;
  localparam int PixCntW = 32;
  localparam int HdrIdxW = 4;
  localparam int NumGlyphs = 91;
  localparam int FontCols = 5;
  localparam int FontRows = 7;
  localparam int CellCols = 6;

  // request selector
  localparam logic [1:0] REQ_CHAR = 2'd0;
  localparam logic [1:0] REQ_FILL = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  // controller commands
  localparam logic [7:0] CMD_COL_SET = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET = 8'h2B;
  localparam logic [7:0] CMD_MEM_WR = 8'h2C;

  localparam logic [7:0] CODE_FIRST = 8'h20;
  localparam logic [7:0] CODE_LAST = 8'h7A;

  // header byte positions
  localparam logic [HdrIdxW-1:0] HDR_COL_CMD = 4'd0;
  localparam logic [HdrIdxW-1:0] HDR_X0_HI = 4'd1;
  localparam logic [HdrIdxW-1:0] HDR_X0_LO = 4'd2;
  localparam logic [HdrIdxW-1:0] HDR_X1_HI = 4'd3;
  localparam logic [HdrIdxW-1:0] HDR_X1_LO = 4'd4;
  localparam logic [HdrIdxW-1:0] HDR_ROW_CMD = 4'd5;
  localparam logic [HdrIdxW-1:0] HDR_Y0_HI = 4'd6;
  localparam logic [HdrIdxW-1:0] HDR_Y0_LO = 4'd7;
  localparam logic [HdrIdxW-1:0] HDR_Y1_HI = 4'd8;
  localparam logic [HdrIdxW-1:0] HDR_Y1_LO = 4'd9;
  localparam logic [HdrIdxW-1:0] HDR_WR_CMD = 4'd10;

  // shape set-up handed to the cell walker
  typedef struct packed {
    logic               load;
    logic               fill;
    logic [GlyphW-1:0]  glyph;
    logic [ScaleW-1:0]  scale;
    logic [ColourW-1:0] fore;
    logic [ColourW-1:0] back;
  } shape_t;

  // column 0 in the top byte; bit r of a column is font row r
  localparam logic [39:0] GLYPH_ROM [NumGlyphs] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700,
    40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
    40'h3649552250, 40'h0005030000, 40'h001C224100,
    40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
    40'h4261514946, 40'h2141454B31, 40'h1814127F10,
    40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000,
    40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E,
    40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
    40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
    40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
    40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
    40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
    40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204,
    40'h4040404040, 40'h0001020400, 40'h2054545478,
    40'h7F48444438, 40'h3844444420, 40'h384444487F,
    40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478,
    40'h7C08040478, 40'h3844444438, 40'h7C14141408,
    40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
    40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44
  };

  function automatic logic glyph_bit(logic [GlyphW-1:0] idx, logic [2:0] col,
                                     logic [2:0] row);
    logic [39:0] cols;
    logic [7:0]  colbits;
    cols = GLYPH_ROM[idx];
    case (col)
      3'd0:    colbits = cols[39:32];
      3'd1:    colbits = cols[31:24];
      3'd2:    colbits = cols[23:16];
      3'd3:    colbits = cols[15:8];
      3'd4:    colbits = cols[7:0];
      default: colbits = 8'h00;
    endcase
    return colbits[row];
  endfunction

endpackage

### hw/rtl/gars_cell_walker.sv
// ----------------------------------------------------------------------------
// gars_cell_walker
// Tracks the pixel position inside a glyph cell and gives the pixel colour.
// ----------------------------------------------------------------------------
module gars_cell_walker
  import gars_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  shape_t             shape_i,
  input  logic               step_i,
  output logic [ColourW-1:0] colour_o
);

  logic               fill_q;
  logic [GlyphW-1:0]  glyph_q;
  logic [ScaleW-1:0]  scale_q;
  logic [ColourW-1:0] fore_q;
  logic [ColourW-1:0] back_q;
  logic [ScaleW-1:0]  sub_col_q, sub_col_d;
  logic [ScaleW-1:0]  sub_row_q, sub_row_d;
  logic [2:0]         font_col_q, font_col_d;
  logic [2:0]         font_row_q, font_row_d;
  logic               ink;

  always_comb begin
    sub_col_d  = sub_col_q;
    sub_row_d  = sub_row_q;
    font_col_d = font_col_q;
    font_row_d = font_row_q;
    if (shape_i.load) begin
      sub_col_d  = '0;
      sub_row_d  = '0;
      font_col_d = '0;
      font_row_d = '0;
    end else if (step_i && !fill_q) begin
      if (sub_col_q == scale_q - ScaleW'(1)) begin
        sub_col_d = '0;
        if (font_col_q == 3'(CellCols - 1)) begin
          // end of a window row: move down one screen row
          font_col_d = '0;
          if (sub_row_q == scale_q - ScaleW'(1)) begin
            sub_row_d  = '0;
            font_row_d = font_row_q + 3'd1;
          end else begin
            sub_row_d = sub_row_q + ScaleW'(1);
          end
        end else begin
          font_col_d = font_col_q + 3'd1;
        end
      end else begin
        sub_col_d = sub_col_q + ScaleW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= 1'b0;
      glyph_q    <= '0;
      scale_q    <= ScaleW'(1);
      sub_col_q  <= '0;
      sub_row_q  <= '0;
      font_col_q <= '0;
      font_row_q <= '0;
    end else begin
      if (shape_i.load) begin
        fill_q  <= shape_i.fill;
        glyph_q <= shape_i.glyph;
        if (!shape_i.fill) begin
          scale_q <= shape_i.scale;
        end
      end
      sub_col_q  <= sub_col_d;
      sub_row_q  <= sub_row_d;
      font_col_q <= font_col_d;
      font_row_q <= font_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shape_i.load) begin
      fore_q <= shape_i.fore;
      back_q <= shape_i.back;
    end
  end

  assign ink = (scale_q != '0) && (font_col_q < 3'(FontCols)) &&
               (font_row_q < 3'(FontRows)) && glyph_bit(glyph_q, font_col_q, font_row_q);

  assign colour_o = (fill_q || ink) ? fore_q : back_q;

endmodule

### hw/rtl/glyph_and_rect_pixel_streamer_core.sv
// ----------------------------------------------------------------------------
// glyph_and_rect_pixel_streamer_core
// Turns character and rectangle requests into a display-controller byte
// stream.
// ----------------------------------------------------------------------------
// Input stream: one request per beat, kind in tuser (char, fill, tick).
// A char or fill request sets up a shape and gives eleven window bytes
// (column command, x0, x1, row command, y0, y1, write command); tready
// stays low after the request until the write command is loaded. Each
// tick then gives one pixel byte, high byte first, row-major; idle ticks
// and unused kinds are dropped.
// Output stream: tdata is the byte, tuser marks data and shape end, tlast
// marks the last byte of each request.
// An accepted request's first output byte is registered on the next clock.
// Throughput: a tick every cycle while the output is not stalled; a shape
// request holds the input while the sequencer walks the window bytes.
// A new shape request abandons an unfinished shape.
// When the receiver stalls, the output register holds its byte and tready
// drops; nothing is lost. Reset empties the output and leaves no shape active.
// ----------------------------------------------------------------------------
module glyph_and_rect_pixel_streamer_core
  import gars_pkg::*;
#(
  parameter int MAX_SCALE = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x[15:0], pos_y[31:16], rect_width[47:32], rect_height[63:48],
  // char_code[71:64], fg_color[87:72], bg_color[103:88], scale[107:104]
  input  logic [111:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_byte[7:0]
  output logic [7:0]   m_axis_tdata,
  // is_data[0], shape_done[1]
  output logic [1:0]   m_axis_tuser,
  // run_last
  output logic         m_axis_tlast
);

  logic [CoordW-1:0]  pos_x, pos_y, rect_width, rect_height;
  logic [7:0]         char_code;
  logic [ColourW-1:0] fg_color, bg_color;
  logic [ScaleW-1:0]  scale, scale_eff;
  logic [1:0]         req_type;

  assign pos_x       = s_axis_tdata[15:0];
  assign pos_y       = s_axis_tdata[31:16];
  assign rect_width  = s_axis_tdata[47:32];
  assign rect_height = s_axis_tdata[63:48];
  assign char_code   = s_axis_tdata[71:64];
  assign fg_color    = s_axis_tdata[87:72];
  assign bg_color    = s_axis_tdata[103:88];
  assign scale       = s_axis_tdata[107:104];
  assign req_type    = s_axis_tuser;

  logic               out_valid_q;
  logic [7:0]         out_byte_q;
  logic               out_data_q, out_last_q, out_done_q;
  logic               hdr_busy_q;
  logic [HdrIdxW-1:0] hdr_idx_q;
  logic [CoordW-1:0]  x0_q, x1_q, y0_q, y1_q;
  logic               hdr_done_q;
  logic               active_q, active_d;
  logic               low_next_q, low_next_d;
  logic [PixCntW-1:0] pix_left_q, pix_left_d;

  logic               load_ok, in_fire, is_shape, is_char, tick_live;
  logic [GlyphW-1:0]  glyph_idx;
  logic [CoordW-1:0]  win_w, win_h, x1_calc, y1_calc;
  logic [7:0]         sq;
  logic [PixCntW-1:0] pix_total;
  logic [ColourW-1:0] colour;
  shape_t             shape;

  logic [7:0]         nxt_byte;
  logic               nxt_data, nxt_last, nxt_done, nxt_valid;

  assign load_ok       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !hdr_busy_q && load_ok;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_char       = (req_type == REQ_CHAR);
  assign is_shape      = is_char || (req_type == REQ_FILL);
  assign tick_live     = in_fire && (req_type == REQ_TICK) && active_q;

  assign scale_eff = (32'(scale) > MAX_SCALE) ? ScaleW'(MAX_SCALE) : scale;
  assign glyph_idx = (char_code >= CODE_FIRST && char_code <= CODE_LAST) ?
                     GlyphW'(char_code - CODE_FIRST) : '0;

  assign win_w   = is_char ? CoordW'(scale_eff) * CoordW'(CellCols) : rect_width;
  assign win_h   = is_char ? CoordW'(scale_eff) * CoordW'(FontRows) : rect_height;
  assign x1_calc = pos_x + win_w - CoordW'(1);
  assign y1_calc = pos_y + win_h - CoordW'(1);

  // 42*s*s as 32+8+2 times the square
  assign sq        = 8'(scale_eff) * 8'(scale_eff);
  assign pix_total = is_char ?
                     ((PixCntW'(sq) << 5) + (PixCntW'(sq) << 3) + (PixCntW'(sq) << 1)) :
                     PixCntW'(rect_width) * PixCntW'(rect_height);

  assign shape.load  = in_fire && is_shape;
  assign shape.fill  = !is_char;
  assign shape.glyph = glyph_idx;
  assign shape.scale = scale_eff;
  assign shape.fore  = fg_color;
  assign shape.back  = bg_color;

  gars_cell_walker u_walker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shape_i  (shape),
    .step_i   (tick_live && low_next_q),
    .colour_o (colour)
  );

  // pixel state
  always_comb begin
    active_d   = active_q;
    low_next_d = low_next_q;
    pix_left_d = pix_left_q;
    if (in_fire && is_shape) begin
      active_d   = (pix_total != '0);
      low_next_d = 1'b0;
      pix_left_d = pix_total;
    end else if (tick_live) begin
      low_next_d = !low_next_q;
      if (low_next_q) begin
        pix_left_d = pix_left_q - PixCntW'(1);
        if (pix_left_q == PixCntW'(1)) begin
          active_d = 1'b0;
        end
      end
    end
  end

  // next output byte
  always_comb begin
    nxt_valid = 1'b0;
    nxt_byte  = CMD_COL_SET;
    nxt_data  = 1'b0;
    nxt_last  = 1'b0;
    nxt_done  = 1'b0;
    if (hdr_busy_q) begin
      nxt_valid = 1'b1;
      nxt_data  = 1'b1;
      case (hdr_idx_q)
        HDR_X0_HI:   nxt_byte = x0_q[15:8];
        HDR_X0_LO:   nxt_byte = x0_q[7:0];
        HDR_X1_HI:   nxt_byte = x1_q[15:8];
        HDR_X1_LO:   nxt_byte = x1_q[7:0];
        HDR_ROW_CMD: begin
          nxt_byte = CMD_ROW_SET;
          nxt_data = 1'b0;
        end
        HDR_Y0_HI:   nxt_byte = y0_q[15:8];
        HDR_Y0_LO:   nxt_byte = y0_q[7:0];
        HDR_Y1_HI:   nxt_byte = y1_q[15:8];
        HDR_Y1_LO:   nxt_byte = y1_q[7:0];
        HDR_WR_CMD: begin
          nxt_byte = CMD_MEM_WR;
          nxt_data = 1'b0;
          nxt_last = 1'b1;
          nxt_done = hdr_done_q;
        end
        default: begin
          nxt_byte = CMD_COL_SET;
          nxt_data = 1'b0;
        end
      endcase
    end else if (in_fire && is_shape) begin
      nxt_valid = 1'b1;
      nxt_byte  = CMD_COL_SET;
    end else if (tick_live) begin
      nxt_valid = 1'b1;
      nxt_data  = 1'b1;
      nxt_last  = 1'b1;
      nxt_byte  = low_next_q ? colour[7:0] : colour[15:8];
      nxt_done  = low_next_q && (pix_left_q == PixCntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hdr_busy_q  <= 1'b0;
      hdr_idx_q   <= HDR_COL_CMD;
      active_q    <= 1'b0;
      low_next_q  <= 1'b0;
      pix_left_q  <= '0;
    end else begin
      active_q   <= active_d;
      low_next_q <= low_next_d;
      pix_left_q <= pix_left_d;
      if (load_ok) begin
        out_valid_q <= nxt_valid;
      end
      if (in_fire && is_shape) begin
        hdr_busy_q <= 1'b1;
        hdr_idx_q  <= HDR_X0_HI;
      end else if (hdr_busy_q && load_ok) begin
        // advance through the window bytes, release input after the last
        if (hdr_idx_q == HDR_WR_CMD) begin
          hdr_busy_q <= 1'b0;
          hdr_idx_q  <= HDR_COL_CMD;
        end else begin
          hdr_idx_q <= hdr_idx_q + HdrIdxW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ok && nxt_valid) begin
      out_byte_q <= nxt_byte;
      out_data_q <= nxt_data;
      out_last_q <= nxt_last;
      out_done_q <= nxt_done;
    end
    if (in_fire && is_shape) begin
      x0_q       <= pos_x;
      x1_q       <= x1_calc;
      y0_q       <= pos_y;
      y1_q       <= y1_calc;
      hdr_done_q <= (pix_total == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = {out_done_q, out_data_q};
  assign m_axis_tlast  = out_last_q;

endmodule

### verif/glyph_and_rect_pixel_streamer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel streamer testbench
// Sends character, fill and tick requests to the streamer core and checks
// every output byte against a cycle-free model of the window header, the
// 5x7 font walk and the fill walk kept in this file. Both stream sides idle
// in random bursts; the closing part runs at full rate.
// ----------------------------------------------------------------------------
module testbench;
  import gars_pkg::*;

  localparam int MaxScale = 8;
  localparam logic [1:0] REQ_SPARE = 2'd3;

  // column 0 in the top byte; bit r of a column is font row r
  localparam logic [39:0] FontBitmap [91] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44
  };

  typedef struct packed {
    logic [3:0]  spare;
    logic [3:0]  scale;
    logic [15:0] bg;
    logic [15:0] fg;
    logic [7:0]  code;
    logic [15:0] h;
    logic [15:0] w;
    logic [15:0] y;
    logic [15:0] x;
  } draw_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_data;
    logic       run_last;
    logic       shape_done;
  } pix_byte_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [7:0]   m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  glyph_and_rect_pixel_streamer_core #(
    .MAX_SCALE(MaxScale)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // model of the shape walker
  logic        shape_on = 1'b0;
  logic        fill_on = 1'b0;
  int unsigned glyph_sel = 0;
  logic [15:0] fore_c = '0;
  logic [15:0] back_c = '0;
  int unsigned scale_cur = 1;
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  logic [31:0] pix_left = '0;
  logic        low_next = 1'b0;
  int unsigned row_len = 0;

  pix_byte_t pending_bytes[$];
  int        mismatches = 0;
  int        live_items = 0;
  bit        quiet = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic draw_req_t rand_req();
    draw_req_t r;
    r.spare = '0;
    r.scale = 4'($urandom_range(0, 15));
    r.bg    = 16'($urandom);
    r.fg    = 16'($urandom);
    r.code  = 8'($urandom);
    r.h     = 16'($urandom);
    r.w     = 16'($urandom);
    r.y     = 16'($urandom);
    r.x     = 16'($urandom);
    return r;
  endfunction

  function automatic logic [15:0] pixel_colour();
    int unsigned fc, fr;
    logic [7:0]  col_bits;
    if (fill_on) return fore_c;
    if (scale_cur == 0) return back_c;
    fc = col_pos / scale_cur;
    fr = row_pos / scale_cur;
    if (fc < FontCols && fr < FontRows) begin
      col_bits = FontBitmap[glyph_sel][8*(FontCols-1-fc) +: 8];
      if (col_bits[fr]) return fore_c;
    end
    return back_c;
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic d, input logic l,
                          input logic done);
    pix_byte_t e;
    e.data       = b;
    e.is_data    = d;
    e.run_last   = l;
    e.shape_done = done;
    pending_bytes.push_back(e);
  endtask

  task automatic predict_stream(input logic [1:0] kind, input draw_req_t r,
                                output int n_out);
    logic [15:0] x_end, y_end, colour;
    int unsigned s;
    n_out = 0;
    if (kind == REQ_CHAR || kind == REQ_FILL) begin
      fore_c   = r.fg;
      back_c   = r.bg;
      col_pos  = 0;
      row_pos  = 0;
      low_next = 1'b0;
      if (kind == REQ_FILL) begin
        fill_on  = 1'b1;
        x_end    = r.x + r.w - 16'd1;
        y_end    = r.y + r.h - 16'd1;
        row_len  = 32'(r.w);
        pix_left = 32'(r.w) * 32'(r.h);
      end else begin
        fill_on   = 1'b0;
        s         = (r.scale > MaxScale) ? MaxScale : 32'(r.scale);
        scale_cur = s;
        // codes outside the font draw a space
        glyph_sel = (r.code >= CODE_FIRST && r.code <= CODE_LAST) ?
                    32'(r.code - CODE_FIRST) : 0;
        x_end     = r.x + 16'(CellCols * s) - 16'd1;
        y_end     = r.y + 16'(FontRows * s) - 16'd1;
        row_len   = CellCols * s;
        pix_left  = CellCols * FontRows * s * s;
      end
      shape_on = (pix_left != 0);
      put_byte(CMD_COL_SET, 1'b0, 1'b0, 1'b0);
      put_byte(r.x[15:8], 1'b1, 1'b0, 1'b0);
      put_byte(r.x[7:0], 1'b1, 1'b0, 1'b0);
      put_byte(x_end[15:8], 1'b1, 1'b0, 1'b0);
      put_byte(x_end[7:0], 1'b1, 1'b0, 1'b0);
      put_byte(CMD_ROW_SET, 1'b0, 1'b0, 1'b0);
      put_byte(r.y[15:8], 1'b1, 1'b0, 1'b0);
      put_byte(r.y[7:0], 1'b1, 1'b0, 1'b0);
      put_byte(y_end[15:8], 1'b1, 1'b0, 1'b0);
      put_byte(y_end[7:0], 1'b1, 1'b0, 1'b0);
      // an empty shape ends on the write command
      put_byte(CMD_MEM_WR, 1'b0, 1'b1, !shape_on);
      n_out = 11;
    end else if (kind == REQ_TICK && shape_on) begin
      colour = pixel_colour();
      if (!low_next) begin
        low_next = 1'b1;
        put_byte(colour[15:8], 1'b1, 1'b1, 1'b0);
      end else begin
        low_next = 1'b0;
        pix_left--;
        col_pos++;
        if (col_pos >= row_len) begin
          col_pos = 0;
          row_pos++;
        end
        if (pix_left == 0) shape_on = 1'b0;
        put_byte(colour[7:0], 1'b1, 1'b1, !shape_on);
      end
      n_out = 1;
    end
  endtask

  task automatic send_item(input logic [1:0] kind, input draw_req_t r);
    int n_out;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_stream(kind, r, n_out);
    if (n_out > 0) live_items++;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(REQ_TICK, rand_req());
  endtask

  task automatic finish_shape();
    while (shape_on) send_item(REQ_TICK, rand_req());
  endtask

  task automatic send_char(input logic [7:0] code, input logic [3:0] s);
    draw_req_t r;
    r       = rand_req();
    r.code  = code;
    r.scale = s;
    send_item(REQ_CHAR, r);
  endtask

  task automatic send_fill(input logic [15:0] w, input logic [15:0] h);
    draw_req_t r;
    r   = rand_req();
    r.w = w;
    r.h = h;
    send_item(REQ_FILL, r);
  endtask

  // hold the input low until every predicted byte has left
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_bytes.size() != 0);
  endtask

  task automatic test_directed();
    draw_req_t r;
    send_item(REQ_TICK, rand_req());
    send_item(REQ_SPARE, rand_req());
    r = rand_req();
    r.code = CODE_LAST; r.scale = 4'd8; r.x = '0; r.y = '0; r.fg = 16'hFFFF; r.bg = '0;
    send_item(REQ_CHAR, r);
    send_ticks(3);
    // abandon the character with an empty fill
    r = rand_req();
    r.x = 16'h1234; r.w = '0; r.h = 16'd5;
    send_item(REQ_FILL, r);
    send_ticks(1);
    send_fill(16'd5, 16'd0);
    r = rand_req();
    r.x = 16'hFFFF; r.y = 16'hFFFF; r.w = 16'hFFFF; r.h = 16'hFFFF; r.fg = 16'hA5C3;
    send_item(REQ_FILL, r);
    send_ticks(4);
    send_char(8'h1F, 4'd0);
    send_ticks(1);
    r = rand_req();
    r.code = 8'hFF; r.scale = 4'hF; r.x = 16'hFFF0; r.y = 16'hFFF0; r.fg = '0;
    r.bg = 16'hFFFF;
    send_item(REQ_CHAR, r);
    send_ticks(2);
    send_item(REQ_SPARE, rand_req());
    send_ticks(1);
    send_char(8'h00, 4'd1);
    send_ticks(1);
    r = rand_req();
    r.x = '0; r.y = '0; r.w = 16'd1; r.h = 16'd1; r.fg = 16'h0001;
    send_item(REQ_FILL, r);
    send_ticks(3);
    wait_drain();
  endtask

  task automatic test_font();
    // one whole glyph, then the start of glyphs spread over the font
    send_char(8'h40, 4'd1);
    finish_shape();
    for (int c = CODE_FIRST; c <= CODE_LAST; c += 18) begin
      send_char(8'(c), 4'd1);
      send_ticks(4);
    end
    wait_drain();
  endtask

  task automatic test_scaled();
    send_char(8'h67, 4'd2);
    send_ticks(26);
    // clamped to the largest scale
    send_char(8'h57, 4'hF);
    send_ticks(4);
    wait_drain();
  endtask

  task automatic test_random();
    bit paused;
    int pick;
    paused     = 1'b0;
    live_items = 0;
    while (live_items < 45) begin
      if (!paused && live_items > 22) begin
        wait_drain();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        if ($urandom_range(0, 3) == 0) begin
          send_char(8'($urandom), 4'd1);
          send_ticks($urandom_range(1, 6));
        end else begin
          send_fill(16'($urandom_range(1, 3)), 16'($urandom_range(1, 3)));
          finish_shape();
        end
      end else if (pick == 7) begin
        send_ticks($urandom_range(1, 4));
      end else if (pick == 8) begin
        send_item(REQ_SPARE, rand_req());
      end else begin
        // broken sequence: full-range shape, cut short by the next request
        send_item($urandom_range(0, 1) ? REQ_FILL : REQ_CHAR, rand_req());
        send_ticks($urandom_range(0, 6));
      end
    end
    wait_drain();
  endtask

  task automatic test_full_rate();
    quiet = 1'b1;
    send_fill(16'd3, 16'd2);
    finish_shape();
    send_char(8'($urandom), 4'd1);
    send_ticks(12);
    send_fill(16'd1, 16'd1);
    finish_shape();
    send_char(8'h41, 4'd2);
    send_ticks(10);
    send_fill(16'd2, 16'd2);
    finish_shape();
    wait_drain();
  endtask

  // receiver with random stall bursts
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 15) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_bytes
    pix_byte_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.data       = m_axis_tdata;
      got.is_data    = m_axis_tuser[0];
      got.run_last   = m_axis_tlast;
      got.shape_done = m_axis_tuser[1];
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected byte %02h data %b last %b done %b", got.data,
                   got.is_data, got.run_last, got.shape_done);
      end else begin
        want = pending_bytes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("byte exp %02h/%b/%b/%b got %02h/%b/%b/%b (data/last/done)",
                     want.data, want.is_data, want.run_last, want.shape_done,
                     got.data, got.is_data, got.run_last, got.shape_done);
        end
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_TICK;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_font();
    test_scaled();
    test_random();
    test_full_rate();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
